// File: hdl/dfr_pkg.sv
package dfr_pkg;

  // Frame store geometry
  localparam int BufferDepth = 16;
  localparam int AddrW       = $clog2(BufferDepth);
  localparam int CountW      = $clog2(BufferDepth + 1);
  localparam int EndMax      = 4;

  // Field widths
  localparam int ByteW   = 8;
  localparam int IndexW  = 4;
  localparam int LengthW = 5;
  localparam int EndLenW = 3;
  localparam int PosW    = 2;
  localparam int CfgIdxW = 3;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_END_LENGTH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_END_BYTE0  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_END_BYTE1  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_END_BYTE2  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_END_BYTE3  = 3'd4;

  // Reset values of the registers
  localparam logic [EndLenW-1:0] END_LENGTH_RST = 3'd1;
  localparam logic [ByteW-1:0]   END_BYTE0_RST  = 8'd10;

  // Packed widths of the output stream
  localparam int OutDataW = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_END,
    ST_DRAIN
  } dfr_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store_first;
    logic store_data;
    logic match_advance;
    logic drain_start;
    logic load_out;
  } dfr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic end_hit;
    logic seq_done;
    logic drain_last;
    logic out_free;
  } dfr_status_t;

endpackage

// File: hdl/dfr_ctrl.sv
module dfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  dfr_pkg::dfr_status_t status,
  output dfr_pkg::dfr_cmd_t    cmd,
  output dfr_pkg::dfr_state_t  state_out
);
  import dfr_pkg::*;

  dfr_state_t state;
  dfr_state_t state_next;
  logic       accept;

  assign s_axis_tready = (state != ST_DRAIN);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign state_out     = state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DATA;
      end
      ST_DATA: begin
        if (accept && status.end_hit) begin
          state_next = status.seq_done ? ST_DRAIN : ST_END;
        end
      end
      ST_END: begin
        if (accept) begin
          if (!status.end_hit) begin
            state_next = ST_IDLE;  // broken end sequence drops the frame
          end else if (status.seq_done) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (status.out_free && status.drain_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.store_first = accept;
      end
      ST_DATA: begin
        if (accept) begin
          cmd.store_data    = !status.end_hit;
          cmd.match_advance = status.end_hit && !status.seq_done;
          cmd.drain_start   = status.end_hit && status.seq_done;
        end
      end
      ST_END: begin
        if (accept && status.end_hit) begin
          cmd.match_advance = !status.seq_done;
          cmd.drain_start   = status.seq_done;
        end
      end
      ST_DRAIN: begin
        cmd.load_out = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/dfr_dp.sv
module dfr_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dfr_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [dfr_pkg::ByteW-1:0]             cfg_data,
  input  logic [dfr_pkg::ByteW-1:0]             rx_byte,
  input  dfr_pkg::dfr_cmd_t                     cmd,
  output dfr_pkg::dfr_status_t                  status,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [dfr_pkg::ByteW-1:0]             frame_byte,
  output logic [dfr_pkg::IndexW-1:0]            byte_index,
  output logic [dfr_pkg::LengthW-1:0]           frame_length,
  output logic                                  last_byte
);
  import dfr_pkg::*;

  logic [EndLenW-1:0] end_length;
  logic [ByteW-1:0]   end_bytes [EndMax];
  logic [EndLenW-1:0] len_eff;

  logic [ByteW-1:0]   frame_store [BufferDepth];
  logic [CountW-1:0]  stored_count;
  logic [PosW-1:0]    end_match_pos;
  logic [PosW:0]      pos_next;
  logic [AddrW-1:0]   wr_addr;
  logic               wr_en;
  logic               full;
  logic [AddrW-1:0]   rd_idx;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      end_length   <= END_LENGTH_RST;
      end_bytes[0] <= END_BYTE0_RST;
      end_bytes[1] <= '0;
      end_bytes[2] <= '0;
      end_bytes[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_END_LENGTH: end_length   <= cfg_data[EndLenW-1:0];
        REG_END_BYTE0:  end_bytes[0] <= cfg_data;
        REG_END_BYTE1:  end_bytes[1] <= cfg_data;
        REG_END_BYTE2:  end_bytes[2] <= cfg_data;
        REG_END_BYTE3:  end_bytes[3] <= cfg_data;
        default: ;  // writes past the register list are ignored
      endcase
    end
  end

  // Clamp end length into 1..EndMax
  always_comb begin
    if (end_length == '0) begin
      len_eff = EndLenW'(1);
    end else if (end_length > EndLenW'(EndMax)) begin
      len_eff = EndLenW'(EndMax);
    end else begin
      len_eff = end_length;
    end
  end

  // End sequence compare; a wrap of the match position also completes
  assign pos_next        = {1'b0, end_match_pos} + (PosW+1)'(1);
  assign status.end_hit  = (rx_byte == end_bytes[end_match_pos]);
  assign status.seq_done = ({1'b0, pos_next} >= {1'b0, len_eff});

  // Match position and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count  <= '0;
      end_match_pos <= '0;
    end else begin
      if (cmd.store_first) begin
        stored_count  <= CountW'(1);
        end_match_pos <= '0;
      end else if (cmd.store_data && !full) begin
        stored_count <= stored_count + CountW'(1);
      end
      if (cmd.match_advance) begin
        end_match_pos <= pos_next[PosW-1:0];
      end else if (cmd.drain_start) begin
        end_match_pos <= '0;
      end
    end
  end

  // Store write; once full the top entry is overwritten
  assign full    = (stored_count >= CountW'(BufferDepth));
  assign wr_en   = cmd.store_first || cmd.store_data;
  assign wr_addr = cmd.store_first ? '0 :
                   full ? AddrW'(BufferDepth - 1) : stored_count[AddrW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[wr_addr] <= rx_byte;
    end
  end

  // Drain read pointer
  assign status.drain_last = ({1'b0, rd_idx} == stored_count - CountW'(1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.drain_start) begin
      rd_idx <= '0;
    end else if (cmd.load_out) begin
      rd_idx <= rd_idx + AddrW'(1);
    end
  end

  // Output register, also the registered read of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frame_byte   <= frame_store[rd_idx];
      byte_index   <= IndexW'(rd_idx);
      frame_length <= LengthW'(stored_count);
      last_byte    <= status.drain_last;
    end
  end

endmodule

// File: hdl/delimited_frame_receiver.sv
// Delimited frame receiver.
// Input stream s_axis carries one received byte per transfer. Bytes are
// collected into a 16-entry frame store until the configured end sequence
// (1 to 4 bytes, newline by default) is seen; the first byte after idle is
// always data. End bytes are not stored, a broken end sequence drops the
// frame, and a full store keeps overwriting its top entry.
// A completed frame leaves on m_axis as one transfer per stored byte, with
// its index, the frame length and tlast on the final byte.
// Throughput: one input byte per cycle while receiving. The byte that
// completes a frame starts a drain that reads the store through the output
// register, one byte per cycle while m_axis_tready is high; s_axis_tready
// stays low during the drain, including any output stall.
// The first byte is loaded into the output register from the drain state.
// When m_axis_tready is low, the output register holds its transfer and the
// drain waits; the receive side is stalled only while draining.
// Configuration (cfg_we, cfg_index, cfg_data) must be written while idle;
// the block does not enforce this. Synchronous reset restores the register
// defaults and returns to idle; the frame store itself is not cleared.
module delimited_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dfr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dfr_pkg::ByteW-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] frame_byte, [11:8] byte_index, [16:12] frame_length, zero pad
  output logic [dfr_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast   // last_byte
);
  import dfr_pkg::*;

  dfr_cmd_t           cmd;
  dfr_status_t        status;
  dfr_state_t         state;
  logic [ByteW-1:0]   frame_byte;
  logic [IndexW-1:0]  byte_index;
  logic [LengthW-1:0] frame_length;

  dfr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd),
    .state_out     (state)
  );

  dfr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (s_axis_tdata),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .frame_byte   (frame_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length),
    .last_byte    (m_axis_tlast)
  );

  assign m_axis_tdata = {(OutDataW - ByteW - IndexW - LengthW)'(0),
                         frame_length, byte_index, frame_byte};

  // Emitted index always lies inside the frame
  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, byte_index} < frame_length))
    else $error("byte index beyond frame length");

  // tlast marks exactly the final index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == ({1'b0, byte_index} == frame_length - 5'd1)))
    else $error("tlast does not match final index");

  // Drain continues without a gap after a non-final transfer
  a_drain_no_gap: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("gap inside frame drain");

  // Input is held off for the whole drain
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (state == ST_DRAIN && !s_axis_tready))
    else $error("input accepted while frame is draining");

endmodule
